// File: rtl/t2a_pkg.sv
// Package with the translation templates, constants and result type for the Thumb translator.
`default_nettype none

package t2a_pkg;

   localparam logic [31:0] AL_BASE       = 32'hE000_0000;
   localparam logic [31:0] UNDEF_BASE    = 32'hE7F0_00F0;
   localparam logic [31:0] SEL_RN_MAP    = 32'h2AAE_280A;
   localparam logic [31:0] SEL_RD_MAP    = 32'hA208_AAAA;
   localparam logic [31:0] SEL_RS_MAP    = 32'h0800_C3F0;
   localparam logic [31:0] SEL_RM_MAP    = 32'hFFF3_BEAF;
   localparam logic [31:0] SHIFT_IMM_OP  = 32'h01B0_0000;
   localparam logic [31:0] PUSH_POP_BASE = 32'h058D_0000;
   localparam logic [31:0] LDM_STM_BASE  = 32'h0880_0000;
   localparam logic [31:0] BRANCH_SEXT   = 32'h00FF_F800;
   localparam logic [31:0] BKPT_BASE     = 32'h020D_DF00;
   localparam logic [31:0] BRANCH_OP     = 32'h0A00_0000;

   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_NONE = 2'd1;
   localparam logic [1:0] SEL_RD   = 2'd2;
   localparam logic [1:0] SEL_RS   = 2'd3;

   localparam logic [31:0] ALU_TMPL [16] = '{
      32'h0010_0000, 32'h0030_0000, 32'h01B0_0010, 32'h01B0_0030,
      32'h01B0_0050, 32'h00B0_0000, 32'h00D0_0000, 32'h01B0_0070,
      32'h0110_0000, 32'h0270_0000, 32'h0150_0000, 32'h0170_0000,
      32'h0190_0000, 32'h0010_0090, 32'h01D0_0000, 32'h01F0_0000
   };

   localparam logic [31:0] LDST_REG_TMPL [8] = '{
      32'h0780_0000, 32'h0180_00B0, 32'h07C0_0000, 32'h0190_00D0,
      32'h0790_0000, 32'h0190_00B0, 32'h07D0_0000, 32'h0190_00F0
   };

   typedef struct packed {
      logic [31:0] arm_word;
      logic        needs_special;
   } t2a_result_type;

endpackage

`default_nettype wire

// File: rtl/t2a_decode.sv
// Combinational translation of one Thumb encoding into its ARM word.
`default_nettype none

module t2a_decode
   import t2a_pkg::*;
(
   input  wire logic [15:0]    thumb,
   output t2a_result_type      result
);

   function automatic logic [2:0] pick_reg(input logic [1:0] sel,
                                           input logic [2:0] rd,
                                           input logic [2:0] rs);
      logic [2:0] r;
      unique case (sel)
         SEL_ZERO: r = 3'd0;
         SEL_NONE: r = 3'd0;
         SEL_RD:   r = rd;
         SEL_RS:   r = rs;
      endcase
      return r;
   endfunction

   logic [31:0] undef_word;
   logic [31:0] w;
   logic        special;
   logic [2:0]  rd;
   logic [2:0]  rs;
   logic [2:0]  rn;
   logic [3:0]  op;
   logic [3:0]  cond;
   logic [4:0]  sh;

   assign rd         = thumb[2:0];
   assign rs         = thumb[5:3];
   assign rn         = thumb[10:8];
   assign op         = thumb[9:6];
   assign cond       = thumb[11:8];
   assign sh         = {op, 1'b0};
   assign undef_word = UNDEF_BASE | {12'd0, thumb[15:4], 4'd0, thumb[3:0]};

   always_comb begin
      w       = AL_BASE;
      special = 1'b0;
      unique case (thumb[15:12])
         4'd0, 4'd1: begin
            if (thumb[12:11] != 2'b11) begin
               w = w | SHIFT_IMM_OP | {16'd0, 1'b0, rd, thumb[10:6], thumb[12:11], 2'b0, rs};
            end else begin
               w = w | (thumb[9] ? 32'h0050_0000 : 32'h0090_0000)
                     | {12'd0, 1'b0, rs, 1'b0, rd, 9'd0, thumb[8:6]};
               if (thumb[10]) w = w | 32'h0200_0000;
            end
         end
         4'd2, 4'd3: begin
            w = w | {24'd0, thumb[7:0]};
            unique case (thumb[12:11])
               2'd0:    w = w | 32'h03B0_0000 | {16'd0, 1'b0, rn, 12'd0};
               2'd1:    w = w | 32'h0350_0000 | {12'd0, 1'b0, rn, 16'd0};
               2'd2:    w = w | 32'h0290_0000 | {12'd0, 1'b0, rn, 1'b0, rn, 12'd0};
               default: w = w | 32'h0250_0000 | {12'd0, 1'b0, rn, 1'b0, rn, 12'd0};
            endcase
         end
         4'd4: begin
            if (thumb[11]) begin
               w       = 32'd0;
               special = 1'b1;
            end else if (thumb[10]) begin
               if (thumb[9:8] != 2'd1) begin
                  w       = 32'd0;
                  special = 1'b1;
               end else begin
                  w = w | 32'h0150_0000 | {12'd0, thumb[7], rd, 12'd0, thumb[6:3]};
               end
            end else begin
               w = w | ALU_TMPL[op]
                     | {12'd0, 1'b0, pick_reg(SEL_RN_MAP[sh +: 2], rd, rs), 16'd0}
                     | {16'd0, 1'b0, pick_reg(SEL_RD_MAP[sh +: 2], rd, rs), 12'd0}
                     | {20'd0, 1'b0, pick_reg(SEL_RS_MAP[sh +: 2], rd, rs), 8'd0}
                     | {28'd0, 1'b0, pick_reg(SEL_RM_MAP[sh +: 2], rd, rs)};
            end
         end
         4'd5: begin
            w = w | LDST_REG_TMPL[thumb[11:9]]
                  | {12'd0, 1'b0, rs, 1'b0, rd, 9'd0, thumb[8:6]};
         end
         4'd6: begin
            w = w | 32'h0580_0000 | {12'd0, 1'b0, rs, 1'b0, rd, 5'd0, thumb[10:6], 2'd0};
            if (thumb[11]) w = w | 32'h0010_0000;
         end
         4'd7: begin
            w = w | 32'h05C0_0000 | {12'd0, 1'b0, rs, 1'b0, rd, 7'd0, thumb[10:6]};
            if (thumb[11]) w = w | 32'h0010_0000;
         end
         4'd8: begin
            w = w | 32'h01C0_00B0
                  | {12'd0, 1'b0, rs, 1'b0, rd, 2'd0, thumb[10:9], 4'd0, thumb[8:6], 1'b0};
            if (thumb[11]) w = w | 32'h0010_0000;
         end
         4'd9: begin
            w = w | PUSH_POP_BASE | {17'd0, thumb[10:8], 2'd0, thumb[7:0], 2'd0};
            if (thumb[11]) w = w | 32'h0010_0000;
         end
         4'd10: begin
            w       = 32'd0;
            special = 1'b1;
         end
         4'd11: begin
            if (thumb[10:9] == 2'b10) begin
               w = w | 32'h000D_0000 | {24'd0, thumb[7:0]};
               if (thumb[11]) begin
                  if (thumb[8]) w = w | 32'h0000_8000;
                  w = w | 32'h08B0_0000;
               end else begin
                  if (thumb[8]) w = w | 32'h0000_4000;
                  w = w | 32'h0920_0000;
               end
            end else if (thumb[8]) begin
               w = undef_word;
            end else if (thumb[11:9] == 3'd0) begin
               w = w | BKPT_BASE | {25'd0, thumb[6:0]}
                     | (thumb[7] ? 32'h0040_0000 : 32'h0080_0000);
            end else if (thumb[11:9] == 3'd7) begin
               w = w | 32'h0120_0070 | {20'd0, thumb[7:4], 4'd0, thumb[3:0]};
            end else begin
               w = undef_word;
            end
         end
         4'd12: begin
            w = w | LDM_STM_BASE | {12'd0, 1'b0, rn, 8'd0, thumb[7:0]};
            if (thumb[11]) begin
               w = w | 32'h0010_0000;
               if (!thumb[{1'b0, rn}]) w = w | 32'h0020_0000;
            end else begin
               w = w | 32'h0020_0000;
            end
         end
         4'd13: begin
            if (cond == 4'd14) begin
               w = undef_word;
            end else if (cond == 4'd15) begin
               w = w | 32'h0F00_0000 | {24'd0, thumb[7:0]};
            end else begin
               w = {cond, 28'd0} | BRANCH_OP | {24'd0, thumb[7:0]};
               if (thumb[7]) w = w | 32'h00FF_FF00;
            end
         end
         default: begin
            if (thumb[12:11] != 2'd0) begin
               w       = 32'd0;
               special = 1'b1;
            end else begin
               w = w | BRANCH_OP | {21'd0, thumb[10:0]};
               if (thumb[10]) w = w | BRANCH_SEXT;
            end
         end
      endcase
   end

   assign result.arm_word      = w;
   assign result.needs_special = special;

endmodule

`default_nettype wire

// File: rtl/thumb_to_arm_translate.sv
// Top level of the Thumb to ARM translator: input register, decoder and result register.
//
//   Channel   Direction  Transfer condition      Payload
//   request   in         start && !busy          req_thumb_instruction
//   response  out        rsp_valid (one cycle)   rsp_arm_word, rsp_needs_special
//
// One instruction is taken in every cycle; busy is never raised.
// After its transfer an instruction is held in the input register, then goes
// through the decoder into the result register.
// Synchronous active-high reset clears both valid flags; payload is not reset.
// The receiver cannot stall, so no result is ever held back.
`default_nettype none

module thumb_to_arm_translate
   import t2a_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_thumb_instruction,
   output logic             rsp_valid,
   output logic [31:0]      rsp_arm_word,
   output logic             rsp_needs_special
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [15:0]    in_instr_ff;
   logic           out_valid_ff;
   t2a_result_type out_result_ff;
   t2a_result_type decoded;

   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) in_instr_ff <= req_thumb_instruction;
      if (in_valid_ff) out_result_ff <= decoded;
   end

   t2a_decode u_decode (
      .thumb  (in_instr_ff),
      .result (decoded)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_arm_word      = out_result_ff.arm_word;
   assign rsp_needs_special = out_result_ff.needs_special;

`ifndef ASSERT_OFF
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> in_valid_ff)
      else $error("accepted instruction did not reach the input register");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |=> rsp_valid)
      else $error("decoded instruction did not produce a result");
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid_ff))
      else $error("result strobe without a preceding transfer");
   a_special_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_needs_special) |-> (rsp_arm_word == 32'd0))
      else $error("special instruction carried a non-zero word");
`endif

endmodule

`default_nettype wire
